// ----- hw/rtl/yenc_body_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// yEnc body decoder assertion macros
// Shared assertion macros, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef YENC_BODY_DECODER_DEFINES_SVH
`define YENC_BODY_DECODER_DEFINES_SVH

`define YENC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define YENC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define YENC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/yenc_pkg.sv -----
// ----------------------------------------------------------------------------
// yEnc body decoder package
// Types, character codes and keyword tables shared by the decoder modules.
// ----------------------------------------------------------------------------
package yenc_pkg;

  localparam int MAX_RES = 5;
  localparam int RES_CW  = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] DEC_OFFSET = 8'd42;
  localparam logic [7:0] ESC_OFFSET = 8'd64;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    KEY_BEGIN = 2'd0,
    KEY_PART  = 2'd1,
    KEY_END   = 2'd2
  } key_t;

  typedef enum logic [6:0] {
    PH_LEAD      = 7'b0000001,
    PH_PARTLINE  = 7'b0000010,
    PH_BODY      = 7'b0000100,
    PH_SKIP_HDR  = 7'b0001000,
    PH_SKIP_PART = 7'b0010000,
    PH_REPLAY    = 7'b0100000,
    PH_DONE      = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic                        at_ls;
    logic                        esc;
    logic                        dot;
    logic [RES_CW-1:0]           cnt;
    logic [MAX_RES-1:0][7:0]     data;
  } fst_t;

  typedef struct packed {
    phase_t          phase;
    fst_t            fs;
    logic [2:0]      mc;
    logic [3:0][7:0] held;
    logic            done;
  } step_t;

  typedef struct packed {
    logic [RES_CW-1:0]       cnt;
    kind_t                   kind;
    logic [MAX_RES-1:0][7:0] data;
  } res_t;

  // Keyword text is stored with the first character in the lowest byte.
  function automatic logic [7:0] kw_char(key_t k, logic [2:0] i);
    logic [7:0][7:0] txt;
    case (k)
      KEY_BEGIN: txt = {8'h00, "nigeby="};
      KEY_PART:  txt = {16'h0000, "trapy="};
      default:   txt = {24'h000000, "dney="};
    endcase
    return txt[i];
  endfunction

  function automatic logic [2:0] kw_len(key_t k);
    logic [2:0] len;
    case (k)
      KEY_BEGIN: len = 3'd7;
      KEY_PART:  len = 3'd6;
      default:   len = 3'd5;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/yenc_in_if.sv -----
// ----------------------------------------------------------------------------
// yEnc input channel
// Valid/ready channel carrying one raw article byte per transaction.
// ----------------------------------------------------------------------------
interface yenc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- hw/rtl/yenc_out_if.sv -----
// ----------------------------------------------------------------------------
// yEnc result channel
// Valid/ready channel carrying one decoded byte or status per transaction.
// ----------------------------------------------------------------------------
interface yenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] kind;
  logic       last_of_run;

  modport source (output valid, output data_byte, output kind, output last_of_run,
                  input ready);
  modport sink (input valid, input data_byte, input kind, input last_of_run,
                output ready);
endinterface

// ----- hw/rtl/yenc_body_decoder.sv -----
// ----------------------------------------------------------------------------
// yEnc body decoder
// Decodes the body of a yEnc article, one raw byte per input transaction.
// ----------------------------------------------------------------------------
// The input channel takes one article byte per transaction, with end_of_input
// set on the last byte of the article. Each byte gives zero to five result
// transactions: decoded bytes, a done status when the trailer line is found,
// or an error status when the input ends before the trailer. The final result
// of a byte carries last_of_run.
// The results of a byte are worked out in the cycle of its acceptance and are
// offered from the next cycle on. A byte that gives at most one result can be
// followed by another in every cycle while the receiver is ready; a byte that
// gives more holds the input while its run drains from the result buffer.
// Reset clears the parse state and empties the result buffer. When the
// receiver stalls, the current result is held and input is refused once the
// buffer cannot be emptied in the same cycle. After the end of an article the
// block starts afresh with the next byte.
// ----------------------------------------------------------------------------
`include "yenc_body_decoder_defines.svh"

module yenc_body_decoder import yenc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  yenc_in_if.sink     in_ch,
  yenc_out_if.source  out_ch
);

  logic                    in_take;
  logic                    out_take;
  res_t                    core_res;
  logic [RES_CW-1:0]       cnt_r;
  logic [RES_CW-1:0]       cnt_nxt;
  logic [RES_CW-1:0]       idx_r;
  logic [RES_CW-1:0]       idx_nxt;
  logic [MAX_RES-1:0][7:0] data_r;
  kind_t                   kind_r;

  yenc_dec_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (in_take),
    .in_byte      (in_ch.in_byte),
    .end_of_input (in_ch.end_of_input),
    .res          (core_res)
  );

  assign out_take = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r == '0) || (cnt_r == RES_CW'(1) && out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign out_ch.valid = (cnt_r != '0);
  assign out_ch.data_byte = data_r[idx_r];
  assign out_ch.kind = kind_r;
  assign out_ch.last_of_run = (cnt_r == RES_CW'(1));

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (in_take) begin
      cnt_nxt = core_res.cnt;
      idx_nxt = '0;
    end else if (out_take) begin
      cnt_nxt = cnt_r - RES_CW'(1);
      if (cnt_r != RES_CW'(1)) begin
        idx_nxt = idx_r + RES_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      data_r <= core_res.data;
      kind_r <= core_res.kind;
    end
  end

  `YENC_ASSERT(a_window, 4'(idx_r) + 4'(cnt_r) <= 4'(MAX_RES), "result window overruns buffer")
  `YENC_ASSERT_NEXT(a_drain, out_take && !in_take, cnt_r == $past(cnt_r) - RES_CW'(1), "drain miscount")
  `YENC_ASSERT_IMP(a_status_alone, out_ch.valid && out_ch.kind != KIND_DATA, out_ch.last_of_run && idx_r == '0, "status not alone")

endmodule

// ----- hw/rtl/yenc_dec_core.sv -----
// ----------------------------------------------------------------------------
// yEnc decoder core
// Holds the parse state and works out, in one pass, the results of one byte.
// ----------------------------------------------------------------------------
module yenc_dec_core import yenc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output res_t       res
);

  phase_t          phase_r;
  logic            las_r;
  logic            esc_r;
  logic            dot_r;
  logic [2:0]      mc_r;
  logic [3:0][7:0] held_r;
  step_t           step_cur;
  step_t           step_nxt;

  function automatic fst_t emit_byte(fst_t s, logic [7:0] b);
    fst_t r;
    r = s;
    if (r.cnt < RES_CW'(MAX_RES)) begin
      r.data[r.cnt] = b;
      r.cnt = r.cnt + RES_CW'(1);
    end
    return r;
  endfunction

  function automatic fst_t feed_byte(fst_t s, logic [7:0] c);
    fst_t r;
    r = s;
    if (r.dot) begin
      r.dot = 1'b0;
      if (c == CH_DOT) begin
        r.at_ls = 1'b0;
        return r;
      end
    end
    if (c == CH_CR) begin
      r.at_ls = 1'b0;
      return r;
    end
    if (c == CH_LF) begin
      r.at_ls = 1'b1;
      return r;
    end
    if (r.at_ls && c == CH_DOT) begin
      r.dot = 1'b1;
    end
    r.at_ls = 1'b0;
    if (r.esc) begin
      r.esc = 1'b0;
      r = emit_byte(r, c - DEC_OFFSET - ESC_OFFSET);
    end else if (c == CH_EQ) begin
      r.esc = 1'b1;
    end else begin
      r = emit_byte(r, c - DEC_OFFSET);
    end
    return r;
  endfunction

  function automatic key_t key_of(logic [3:0][7:0] held);
    key_t k;
    if (held[2] == kw_char(KEY_BEGIN, 3'd2)) begin
      k = KEY_BEGIN;
    end else if (held[2] == kw_char(KEY_PART, 3'd2)) begin
      k = KEY_PART;
    end else begin
      k = KEY_END;
    end
    return k;
  endfunction

  function automatic step_t match_byte(step_t s, logic [7:0] c);
    step_t      r;
    logic [2:0] mc;
    logic       ok;
    key_t       k;
    r = s;
    mc = s.mc;
    k = key_of(s.held);
    case (mc)
      3'd0:    ok = (c == CH_EQ);
      3'd1:    ok = (c == kw_char(KEY_END, 3'd1));
      3'd2:    ok = (c == kw_char(KEY_END, 3'd2)) ||
                    (c == kw_char(KEY_BEGIN, 3'd2) && s.phase == PH_LEAD) ||
                    (c == kw_char(KEY_PART, 3'd2) && s.phase == PH_PARTLINE);
      default: ok = (mc < kw_len(k)) && (c == kw_char(k, mc));
    endcase
    if (ok) begin
      if (mc < 3'd4) begin
        r.held[mc[1:0]] = c;
      end
      mc = mc + 3'd1;
      r.mc = mc;
      if (mc >= 3'd3) begin
        k = key_of(r.held);
        if (mc == kw_len(k)) begin
          r.mc = 3'd0;
          r.fs.at_ls = 1'b0;
          case (k)
            KEY_BEGIN: r.phase = PH_SKIP_HDR;
            KEY_PART:  r.phase = PH_SKIP_PART;
            default: begin
              r.phase = PH_DONE;
              r.done = 1'b1;
            end
          endcase
        end
      end
      return r;
    end
    if (mc < 3'd3) begin
      k = KEY_END;
    end
    r.mc = 3'd0;
    r.phase = PH_BODY;
    // Bytes held back by a failed keyword match are decoded in order.
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < mc) begin
        r.fs = feed_byte(r.fs, (i < 4) ? s.held[i[1:0]] : kw_char(k, 3'(i)));
      end
    end
    if (r.fs.cnt >= RES_CW'(MAX_RES)) begin
      r.held[0] = c;
      r.phase = PH_REPLAY;
    end else begin
      r.fs = feed_byte(r.fs, c);
    end
    return r;
  endfunction

  function automatic step_t line_byte(step_t s, logic [7:0] c);
    step_t r;
    r = s;
    if (!s.fs.esc && (s.mc != 3'd0 || (s.fs.at_ls && c == CH_EQ))) begin
      return match_byte(s, c);
    end
    if (s.phase == PH_LEAD && (c == CH_CR || c == CH_LF)) begin
      return r;
    end
    r.phase = PH_BODY;
    r.fs = feed_byte(r.fs, c);
    return r;
  endfunction

  always_comb begin
    step_cur.phase = phase_r;
    step_cur.fs.at_ls = las_r;
    step_cur.fs.esc = esc_r;
    step_cur.fs.dot = dot_r;
    step_cur.fs.cnt = '0;
    step_cur.fs.data = '0;
    step_cur.mc = mc_r;
    step_cur.held = held_r;
    step_cur.done = 1'b0;
    step_nxt = step_cur;
    unique case (phase_r)
      PH_DONE: begin
        step_nxt = step_cur;
      end
      PH_SKIP_HDR: begin
        if (in_byte == CH_LF) begin
          step_nxt.phase = PH_PARTLINE;
          step_nxt.fs.at_ls = 1'b1;
          step_nxt.mc = 3'd0;
        end
      end
      PH_SKIP_PART: begin
        if (in_byte == CH_LF) begin
          step_nxt.phase = PH_BODY;
          step_nxt.fs.at_ls = 1'b1;
          step_nxt.mc = 3'd0;
        end
      end
      PH_REPLAY: begin
        step_nxt.phase = PH_BODY;
        step_nxt.fs = feed_byte(step_nxt.fs, held_r[0]);
        step_nxt = line_byte(step_nxt, in_byte);
      end
      default: begin
        step_nxt = line_byte(step_cur, in_byte);
      end
    endcase
  end

  always_comb begin
    res.data = '0;
    res.kind = KIND_DATA;
    res.cnt = '0;
    if (phase_r == PH_DONE) begin
      res.cnt = '0;
    end else if (step_nxt.done || end_of_input) begin
      res.cnt = RES_CW'(1);
      res.kind = step_nxt.done ? KIND_DONE : KIND_ERROR;
    end else begin
      res.cnt = step_nxt.fs.cnt;
      res.data = step_nxt.fs.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      las_r <= 1'b1;
      esc_r <= 1'b0;
      dot_r <= 1'b0;
      mc_r <= 3'd0;
    end else if (take) begin
      if (end_of_input) begin
        phase_r <= PH_LEAD;
        las_r <= 1'b1;
        esc_r <= 1'b0;
        dot_r <= 1'b0;
        mc_r <= 3'd0;
      end else begin
        phase_r <= step_nxt.phase;
        las_r <= step_nxt.fs.at_ls;
        esc_r <= step_nxt.fs.esc;
        dot_r <= step_nxt.fs.dot;
        mc_r <= step_nxt.mc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_r <= step_nxt.held;
    end
  end

endmodule

// ----- tb/tb_yenc_body_decoder.sv -----
// ----------------------------------------------------------------------------
// yEnc body decoder testbench
// Feeds whole articles byte by byte through the valid/ready input channel.
// A scoreboard keeps its own model of the decoder, predicts every result
// transaction and compares each field of what comes out. The run covers
// headers, part lines, dot-stuffing, escapes across line breaks, keyword near
// misses, trailers, early ends and random noise. It varies idling on both
// sides and includes one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_yenc_body_decoder import yenc_pkg::*; ();

  localparam int HOLD_CYCLES  = 100;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } article_result_t;

  class yenc_scoreboard;
    phase_t          phase;
    logic            at_ls;
    logic            esc;
    logic            dot;
    logic [2:0]      mc;
    logic [7:0]      held [4];
    logic [7:0]      run_bytes [$];
    bit              trailer_hit;
    article_result_t expected_results [$];
    int              errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase = PH_LEAD;
      at_ls = 1'b1;
      esc   = 1'b0;
      dot   = 1'b0;
      mc    = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function string keyword(key_t k);
      case (k)
        KEY_BEGIN: return "=ybegin";
        KEY_PART:  return "=ypart";
        default:   return "=yend";
      endcase
    endfunction

    function key_t held_key();
      if (held[2] == "b") return KEY_BEGIN;
      if (held[2] == "p") return KEY_PART;
      return KEY_END;
    endfunction

    function bit third_char_ok(logic [7:0] c);
      return (c == "e") || (c == "b" && phase == PH_LEAD) ||
             (c == "p" && phase == PH_PARTLINE);
    endfunction

    function void push_decoded(logic [7:0] v);
      if (run_bytes.size() < MAX_RES) run_bytes.push_back(v);
    endfunction

    function void decode_char(logic [7:0] c);
      if (dot) begin
        dot = 1'b0;
        if (c == CH_DOT) begin
          at_ls = 1'b0;
          return;
        end
      end
      if (c == CH_CR) begin
        at_ls = 1'b0;
        return;
      end
      if (c == CH_LF) begin
        at_ls = 1'b1;
        return;
      end
      if (at_ls && c == CH_DOT) dot = 1'b1;
      at_ls = 1'b0;
      if (esc) begin
        esc = 1'b0;
        push_decoded(c - ESC_OFFSET - DEC_OFFSET);
      end else if (c == CH_EQ) begin
        esc = 1'b1;
      end else begin
        push_decoded(c - DEC_OFFSET);
      end
    endfunction

    function void match_char(logic [7:0] c);
      int         m;
      int         i;
      bit         ok;
      key_t       k;
      string      kw;
      logic [7:0] ch;
      m = int'(mc);
      if (m == 0) ok = (c == CH_EQ);
      else if (m == 1) ok = (c == "y");
      else if (m == 2) ok = third_char_ok(c);
      else begin
        kw = keyword(held_key());
        ok = (m < kw.len()) && (c == kw[m]);
      end
      if (ok) begin
        if (m < 4) held[m] = c;
        m++;
        mc = 3'(m);
        if (m >= 3) begin
          k  = held_key();
          kw = keyword(k);
          if (m == kw.len()) begin
            mc    = '0;
            at_ls = 1'b0;
            case (k)
              KEY_BEGIN: phase = PH_SKIP_HDR;
              KEY_PART:  phase = PH_SKIP_PART;
              default: begin
                phase       = PH_DONE;
                trailer_hit = 1'b1;
              end
            endcase
          end
        end
        return;
      end
      k  = (m >= 3) ? held_key() : KEY_END;
      kw = keyword(k);
      mc = '0;
      phase = PH_BODY;
      for (i = 0; i < m; i++) begin
        if (i < 4) ch = held[i];
        else ch = kw[i];
        decode_char(ch);
      end
      if (run_bytes.size() >= MAX_RES) begin
        held[0] = c;
        phase   = PH_REPLAY;
      end else begin
        decode_char(c);
      end
    endfunction

    function void line_char(logic [7:0] c);
      if (!esc && (mc != 0 || (at_ls && c == CH_EQ))) begin
        match_char(c);
        return;
      end
      if (phase == PH_LEAD && (c == CH_CR || c == CH_LF)) return;
      phase = PH_BODY;
      decode_char(c);
    endfunction

    function void note_byte(logic [7:0] c, logic eoi);
      article_result_t r;
      int              i;
      run_bytes.delete();
      trailer_hit = 1'b0;
      case (phase)
        PH_DONE: begin
          if (eoi) clear_state();
          return;
        end
        PH_SKIP_HDR: begin
          if (c == CH_LF) begin
            phase = PH_PARTLINE;
            at_ls = 1'b1;
            mc    = '0;
          end
        end
        PH_SKIP_PART: begin
          if (c == CH_LF) begin
            phase = PH_BODY;
            at_ls = 1'b1;
            mc    = '0;
          end
        end
        PH_REPLAY: begin
          phase = PH_BODY;
          decode_char(held[0]);
          line_char(c);
        end
        default: line_char(c);
      endcase
      if (trailer_hit || eoi) begin
        r.data = 8'h00;
        if (trailer_hit) r.kind = KIND_DONE;
        else r.kind = KIND_ERROR;
        r.last = 1'b1;
        expected_results.push_back(r);
        if (eoi) clear_state();
        return;
      end
      for (i = 0; i < run_bytes.size(); i++) begin
        r.data = run_bytes[i];
        r.kind = KIND_DATA;
        r.last = (i == run_bytes.size() - 1);
        expected_results.push_back(r);
      end
    endfunction

    function void check_result(logic [7:0] data, logic [1:0] kind, logic last);
      article_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: data=%h kind=%0d last=%b",
                 $time, data, kind, last);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (e.data !== data || e.kind !== kind || e.last !== last) begin
        $display("%0t: result mismatch: expected data=%h kind=%0d last=%b,",
                 $time, e.data, e.kind, e.last);
        $display("%0t:   actual data=%h kind=%0d last=%b",
                 $time, data, kind, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  yenc_in_if  in_ch ();
  yenc_out_if out_ch ();

  yenc_body_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  yenc_scoreboard sb;
  int             src_idle_pct;
  int             sink_idle_pct;
  bit             hold_req;
  int             quiet_cycles;
  int             items_sent;
  logic [7:0]     article [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1) begin
        if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
          sb.note_byte(in_ch.in_byte, in_ch.end_of_input);
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
          sb.check_result(out_ch.data_byte, out_ch.kind, out_ch.last_of_run);
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
          quiet_cycles = 0;
        else
          quiet_cycles++;
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) article.push_back(s[i]);
  endfunction

  function automatic void add_printable(int n);
    repeat (n) article.push_back(8'($urandom_range(32, 126)));
  endfunction

  function automatic void add_crlf();
    article.push_back(CH_CR);
    article.push_back(CH_LF);
  endfunction

  function automatic void make_article();
    string hdr_txt;
    article.delete();
    repeat ($urandom_range(0, 2)) article.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) article.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        add_text("=ybegin");
        add_printable($urandom_range(0, 6));
        add_crlf();
        if ($urandom_range(0, 9) < 7) begin
          add_text("=ypart");
          add_printable($urandom_range(0, 4));
          add_crlf();
        end else if ($urandom_range(0, 1) == 1) begin
          add_text("=ypar");
          article.push_back(8'($urandom_range(0, 255)));
        end
      end
      6: begin
        add_text("=ybegi");
        article.push_back(8'($urandom_range(0, 255)));
      end
      7: begin
        hdr_txt = "=ybegin";
        add_text(hdr_txt.substr(0, $urandom_range(0, 4)));
        article.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 9))
        0, 1: add_text("..");
        2:    add_text("=ye");
        3:    add_text("=yen");
        4: begin
          article.push_back(CH_EQ);
          add_crlf();
          add_text("..");
        end
        default: ;
      endcase
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(0, 4) == 0) article.push_back(CH_EQ);
        article.push_back(8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 2))
        0: add_crlf();
        1: article.push_back(CH_LF);
        default: begin
          article.push_back(CH_EQ);
          add_crlf();
        end
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      add_text("=yend");
      if ($urandom_range(0, 3) != 0) begin
        add_text(" size=");
        add_printable($urandom_range(0, 4));
        add_crlf();
      end
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic eoi);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_article();
    int i;
    for (i = 0; i < article.size(); i++) send_byte(article[i], i == article.size() - 1);
    items_sent += article.size();
  endtask

  initial begin
    sb            = new();
    hold_req      = 1'b0;
    items_sent    = 0;
    src_idle_pct  = 26;
    sink_idle_pct = 54;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.in_byte      <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // A header that fails on its last letter, extreme bytes, a trailer and an
    // ignored byte at the end of the article.
    article.delete();
    add_text("=ybegi");
    article.push_back(8'hFF);
    article.push_back(CH_LF);
    add_text("=yend");
    article.push_back(8'h00);
    send_article();

    // Escapes across line breaks, an escaped stuffed dot, an escape in front
    // of a keyword and an article that ends without a trailer.
    article.delete();
    add_crlf();
    article.push_back(CH_EQ);
    article.push_back(CH_LF);
    add_text("..");
    article.push_back(CH_LF);
    article.push_back(CH_EQ);
    article.push_back(CH_LF);
    add_text("=y");
    article.push_back(8'h00);
    send_article();

    while (items_sent < 120) begin
      make_article();
      send_article();
    end

    src_idle_pct  = 54;
    sink_idle_pct = 26;
    while (items_sent < 240) begin
      make_article();
      send_article();
    end

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req      = 1'b1;
    while (items_sent < 350) begin
      make_article();
      send_article();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
